// File: sv/lls_pkg.sv
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types, token kind codes and keyword tables for the lexical scanner.
// ----------------------------------------------------------------------------
package lls_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int SLOTS = 4;
  localparam logic [31:0] MAX_POS = 32'hFFFF_FFFF;

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_BANG_EQ = 6'd12;
  localparam logic [5:0] K_EQ      = 6'd13;
  localparam logic [5:0] K_EQ_EQ   = 6'd14;
  localparam logic [5:0] K_GT      = 6'd15;
  localparam logic [5:0] K_GT_EQ   = 6'd16;
  localparam logic [5:0] K_LT      = 6'd17;
  localparam logic [5:0] K_LT_EQ   = 6'd18;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_KW_BASE = 6'd22;
  localparam logic [5:0] K_END     = 6'd38;
  localparam logic [5:0] K_BAD     = 6'd39;
  localparam logic [5:0] K_UNTERM  = 6'd40;

  // Pending operator codes.
  localparam logic [2:0] OP_BANG  = 3'd0;
  localparam logic [2:0] OP_EQ    = 3'd1;
  localparam logic [2:0] OP_LT    = 3'd2;
  localparam logic [2:0] OP_GT    = 3'd3;
  localparam logic [2:0] OP_SLASH = 3'd4;

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_COMMENT, M_STRING, M_INT, M_DOT, M_FRAC, M_IDENT
  } mode_t;

  typedef enum logic [1:0] {LEN_SPAN, LEN_ONE, LEN_ZERO} len_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [31:0] token_length;
    logic [31:0] line_number;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] start;
    logic [31:0] stop;
    logic [31:0] line;
    len_t        lmode;
  } slot_t;

  typedef struct packed {
    logic [2:0]        cnt;
    slot_t [SLOTS-1:0] slot;
  } event_t;

  function automatic slot_t mk(logic [5:0] kind, logic [31:0] start, logic [31:0] stop,
                               logic [31:0] line, len_t lmode);
    slot_t s;
    s.kind = kind;
    s.start = start;
    s.stop = stop;
    s.line = line;
    s.lmode = lmode;
    return s;
  endfunction

  // Keyword text, stored with the first character in the low byte.
  function automatic logic [47:0] kw_text(logic [3:0] k);
    logic [47:0] t;
    case (k)
      4'd0: t = 48'("dna");
      4'd1: t = 48'("ssalc");
      4'd2: t = 48'("esle");
      4'd3: t = 48'("eslaf");
      4'd4: t = 48'("nuf");
      4'd5: t = 48'("rof");
      4'd6: t = 48'("fi");
      4'd7: t = 48'("lin");
      4'd8: t = 48'("ro");
      4'd9: t = 48'("tnirp");
      4'd10: t = 48'("nruter");
      4'd11: t = 48'("repus");
      4'd12: t = 48'("siht");
      4'd13: t = 48'("eurt");
      4'd14: t = 48'("rav");
      default: t = 48'("elihw");
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(logic [3:0] k);
    logic [2:0] n;
    case (k)
      4'd0, 4'd4, 4'd5, 4'd7, 4'd14: n = 3'd3;
      4'd2, 4'd12, 4'd13: n = 3'd4;
      4'd6, 4'd8: n = 3'd2;
      4'd10: n = 3'd6;
      default: n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic logic [5:0] ident_kind(logic [47:0] kb, logic [2:0] il);
    logic [5:0] r;
    r = K_IDENT;
    for (int k = 0; k < 16; k++) begin
      if (il == kw_len(4'(k)) && kb == kw_text(4'(k))) r = K_KW_BASE + 6'(k);
    end
    return r;
  endfunction

  function automatic logic [5:0] op_single(logic [2:0] p);
    logic [5:0] r;
    case (p)
      OP_BANG, 3'd5: r = K_BANG;
      OP_EQ, 3'd6: r = K_EQ;
      OP_LT, 3'd7: r = K_LT;
      OP_GT: r = K_GT;
      default: r = K_SLASH;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] op_double(logic [2:0] p);
    logic [5:0] r;
    case (p)
      OP_BANG: r = K_BANG_EQ;
      OP_EQ: r = K_EQ_EQ;
      OP_LT: r = K_LT_EQ;
      default: r = K_GT_EQ;
    endcase
    return r;
  endfunction

  // Pending operator reduced to its five meaningful codes.
  function automatic logic [2:0] op_mod(logic [2:0] p);
    return (p > OP_SLASH) ? p - 3'd5 : p;
  endfunction

endpackage

// File: sv/lox_lexical_scanner.sv
// A token is registered in the bundle queue and then in the output register before it
// can be taken from the result ports.
// Throughput: one byte per cycle; the emitter gives one token per cycle while popped, so
// multi-token bytes draw on the four-bundle queue, and push stalls when it fills.
// Reset: synchronous rst returns the scanner to idle at offset 0, line 1, and empties
// the queue and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// lox_lexical_scanner
// Streaming lexical scanner: source bytes in, tokens out.
// ----------------------------------------------------------------------------
module lox_lexical_scanner (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  lls_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output lls_pkg::out_t token
);
  import lls_pkg::*;

  event_t ev, head;
  logic   ev_push, head_valid, head_pop, accept;

  assign accept = push && !full;

  lls_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .item(item), .ev_push(ev_push), .ev(ev)
  );

  lls_fifo u_fifo (
    .clk(clk), .rst(rst), .wr_en(ev_push), .wr_data(ev), .rd_en(head_pop),
    .rd_data(head), .rd_valid(head_valid), .full(full)
  );

  lls_back u_back (
    .clk(clk), .rst(rst), .head(head), .head_valid(head_valid), .head_pop(head_pop),
    .pop(pop), .empty(empty), .token(token)
  );

endmodule

// File: sv/lls_front.sv
// ----------------------------------------------------------------------------
// lls_front
// Scans one source byte per cycle while bytes are accepted and emits a bundle
// of up to four token records for that byte.
// ----------------------------------------------------------------------------
module lls_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  lls_pkg::in_t   item,
  output logic           ev_push,
  output lls_pkg::event_t ev
);
  import lls_pkg::*;

  mode_t       mode, mode_next;
  logic [2:0]  pend, pend_next;
  logic [31:0] pos, pos_next;
  logic [31:0] tstart, tstart_next;
  logic [31:0] line, line_next;
  logic [47:0] kbuf, kbuf_next;
  logic [2:0]  ilen, ilen_next;

  logic [7:0]  c;
  logic [2:0]  cnt;
  logic        rescan;
  logic [31:0] dot;
  logic        do_fin;

  always_comb begin
    c = item.source_byte;
    mode_next = mode;
    pend_next = pend;
    tstart_next = tstart;
    line_next = line;
    kbuf_next = kbuf;
    ilen_next = ilen;
    pos_next = (pos == MAX_POS) ? pos : pos + 32'd1;
    ev = '0;
    cnt = 3'd0;
    rescan = 1'b0;
    dot = '0;
    do_fin = 1'b0;

    case (mode)
      M_OP: begin
        if (c == "=" && op_mod(pend) < OP_SLASH) begin
          ev.slot[cnt[1:0]] = mk(op_double(op_mod(pend)), tstart, pos_next, line, LEN_SPAN);
          cnt = cnt + 3'd1;
          mode_next = M_IDLE;
        end else if (c == "/" && op_mod(pend) == OP_SLASH) begin
          mode_next = M_COMMENT;
        end else begin
          do_fin = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == "\n") begin
          if (line_next != MAX_POS) line_next = line_next + 32'd1;
          mode_next = M_IDLE;
        end
      end
      M_STRING: begin
        if (c == "\"") begin
          ev.slot[cnt[1:0]] = mk(K_STRING, tstart, pos_next, line, LEN_SPAN);
          cnt = cnt + 3'd1;
          mode_next = M_IDLE;
        end else if (c == "\n" && line_next != MAX_POS) begin
          line_next = line_next + 32'd1;
        end
      end
      M_INT: begin
        if (c == ".") mode_next = M_DOT;
        else if (!(c inside {["0":"9"]})) do_fin = 1'b1;
      end
      M_DOT: begin
        if (c inside {["0":"9"]}) mode_next = M_FRAC;
        else do_fin = 1'b1;
      end
      M_FRAC: begin
        if (!(c inside {["0":"9"]})) do_fin = 1'b1;
      end
      M_IDENT: begin
        if (c inside {["a":"z"], ["A":"Z"], ["0":"9"], "_"}) begin
          if (ilen < 3'd6) kbuf_next[{ilen, 3'b000} +: 8] = c;
          if (ilen < 3'd7) ilen_next = ilen + 3'd1;
        end else begin
          do_fin = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    // Close the open lookahead token at this byte, then scan the byte afresh.
    if (do_fin) begin
      rescan = 1'b1;
      dot = (pos != 32'd0) ? pos - 32'd1 : 32'd0;
      case (mode)
        M_OP: begin
          ev.slot[cnt[1:0]] = mk(op_single(pend), tstart, tstart, line, LEN_ONE);
          cnt = cnt + 3'd1;
        end
        M_INT, M_FRAC: begin
          ev.slot[cnt[1:0]] = mk(K_NUMBER, tstart, pos, line, LEN_SPAN);
          cnt = cnt + 3'd1;
        end
        M_DOT: begin
          ev.slot[cnt[1:0]] = mk(K_NUMBER, tstart, dot, line, LEN_SPAN);
          cnt = cnt + 3'd1;
          ev.slot[cnt[1:0]] = mk(K_DOT, dot, dot, line, LEN_ONE);
          cnt = cnt + 3'd1;
        end
        M_IDENT: begin
          ev.slot[cnt[1:0]] = mk(ident_kind(kbuf, ilen), tstart, pos, line, LEN_SPAN);
          cnt = cnt + 3'd1;
        end
        default: ;
      endcase
      mode_next = M_IDLE;
    end

    if (rescan) begin
      mode_next = M_IDLE;
      tstart_next = pos;
      case (c)
        "(": begin ev.slot[cnt[1:0]] = mk(K_LPAREN, pos, pos, line_next, LEN_ONE); cnt++; end
        ")": begin ev.slot[cnt[1:0]] = mk(K_RPAREN, pos, pos, line_next, LEN_ONE); cnt++; end
        "{": begin ev.slot[cnt[1:0]] = mk(K_LBRACE, pos, pos, line_next, LEN_ONE); cnt++; end
        "}": begin ev.slot[cnt[1:0]] = mk(K_RBRACE, pos, pos, line_next, LEN_ONE); cnt++; end
        ",": begin ev.slot[cnt[1:0]] = mk(K_COMMA, pos, pos, line_next, LEN_ONE); cnt++; end
        ".": begin ev.slot[cnt[1:0]] = mk(K_DOT, pos, pos, line_next, LEN_ONE); cnt++; end
        "-": begin ev.slot[cnt[1:0]] = mk(K_MINUS, pos, pos, line_next, LEN_ONE); cnt++; end
        "+": begin ev.slot[cnt[1:0]] = mk(K_PLUS, pos, pos, line_next, LEN_ONE); cnt++; end
        ";": begin ev.slot[cnt[1:0]] = mk(K_SEMI, pos, pos, line_next, LEN_ONE); cnt++; end
        "*": begin ev.slot[cnt[1:0]] = mk(K_STAR, pos, pos, line_next, LEN_ONE); cnt++; end
        "!": begin mode_next = M_OP; pend_next = OP_BANG; end
        "=": begin mode_next = M_OP; pend_next = OP_EQ; end
        "<": begin mode_next = M_OP; pend_next = OP_LT; end
        ">": begin mode_next = M_OP; pend_next = OP_GT; end
        "/": begin mode_next = M_OP; pend_next = OP_SLASH; end
        "\"": mode_next = M_STRING;
        " ", "\r", "\t": ;
        "\n": begin
          if (line_next != MAX_POS) line_next = line_next + 32'd1;
        end
        default: begin
          if (c inside {["0":"9"]}) begin
            mode_next = M_INT;
          end else if (c inside {["a":"z"], ["A":"Z"], "_"}) begin
            mode_next = M_IDENT;
            kbuf_next = {40'd0, c};
            ilen_next = 3'd1;
          end else begin
            ev.slot[cnt[1:0]] = mk(K_BAD, pos, pos, line_next, LEN_ONE);
            cnt = cnt + 3'd1;
          end
        end
      endcase
    end

    // Last byte: close whatever is open, add the end token, return to reset.
    if (item.end_of_source) begin
      dot = (pos_next != 32'd0) ? pos_next - 32'd1 : 32'd0;
      case (mode_next)
        M_STRING: begin
          ev.slot[cnt[1:0]] = mk(K_UNTERM, tstart_next, pos_next, line_next, LEN_SPAN);
          cnt = cnt + 3'd1;
        end
        M_OP: begin
          ev.slot[cnt[1:0]] = mk(op_single(pend_next), tstart_next, tstart_next, line_next,
                                 LEN_ONE);
          cnt = cnt + 3'd1;
        end
        M_INT, M_FRAC: begin
          ev.slot[cnt[1:0]] = mk(K_NUMBER, tstart_next, pos_next, line_next, LEN_SPAN);
          cnt = cnt + 3'd1;
        end
        M_DOT: begin
          ev.slot[cnt[1:0]] = mk(K_NUMBER, tstart_next, dot, line_next, LEN_SPAN);
          cnt = cnt + 3'd1;
          ev.slot[cnt[1:0]] = mk(K_DOT, dot, dot, line_next, LEN_ONE);
          cnt = cnt + 3'd1;
        end
        M_IDENT: begin
          ev.slot[cnt[1:0]] = mk(ident_kind(kbuf_next, ilen_next), tstart_next, pos_next,
                                 line_next, LEN_SPAN);
          cnt = cnt + 3'd1;
        end
        default: ;
      endcase
      ev.slot[cnt[1:0]] = mk(K_END, pos_next, pos_next, line_next, LEN_ZERO);
      cnt = cnt + 3'd1;
      mode_next = M_IDLE;
      pend_next = OP_BANG;
      pos_next = '0;
      tstart_next = '0;
      line_next = 32'd1;
      kbuf_next = '0;
      ilen_next = '0;
    end
    ev.cnt = cnt;
  end

  assign ev_push = accept && (ev.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= OP_BANG;
      pos <= '0;
      tstart <= '0;
      line <= 32'd1;
      kbuf <= '0;
      ilen <= '0;
    end else if (accept) begin
      mode <= mode_next;
      pend <= pend_next;
      pos <= pos_next;
      tstart <= tstart_next;
      line <= line_next;
      kbuf <= kbuf_next;
      ilen <= ilen_next;
    end
  end

endmodule

// File: sv/lls_fifo.sv
// ----------------------------------------------------------------------------
// lls_fifo
// Short queue of token bundles between the scanner and the token emitter.
// ----------------------------------------------------------------------------
module lls_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  lls_pkg::event_t wr_data,
  input  logic            rd_en,
  output lls_pkg::event_t rd_data,
  output logic            rd_valid,
  output logic            full
);
  import lls_pkg::*;

  event_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QPTR_BITS:0]   count;

  assign full = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + QPTR_BITS'(1);
      if (rd_en) rptr <= rptr + QPTR_BITS'(1);
      count <= count + (QPTR_BITS+1)'(wr_en) - (QPTR_BITS+1)'(rd_en);
    end
  end

endmodule

// File: sv/lls_back.sv
// ----------------------------------------------------------------------------
// lls_back
// Walks the token records of each bundle and presents them from an output
// register, one result per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module lls_back (
  input  logic            clk,
  input  logic            rst,
  input  lls_pkg::event_t head,
  input  logic            head_valid,
  output logic            head_pop,
  input  logic            pop,
  output logic            empty,
  output lls_pkg::out_t   token
);
  import lls_pkg::*;

  logic [1:0] idx;
  logic       ovalid;
  out_t       outq, outq_next;
  slot_t      s;
  logic       load, is_last;

  assign s = head.slot[idx];
  assign is_last = ({1'b0, idx} == head.cnt - 3'd1);
  assign load = head_valid && (!ovalid || pop);
  assign head_pop = load && is_last;
  assign empty = !ovalid;
  assign token = outq;

  always_comb begin
    outq_next.token_kind = s.kind;
    outq_next.start_offset = s.start;
    outq_next.line_number = s.line;
    outq_next.last_of_run = is_last;
    case (s.lmode)
      LEN_ONE: outq_next.token_length = 32'd1;
      LEN_ZERO: outq_next.token_length = 32'd0;
      default: outq_next.token_length = (s.stop >= s.start) ? s.stop - s.start : 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) outq <= outq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    ovalid && outq.token_kind == K_END |-> outq.last_of_run)
    else $error("end token is not the last of its run");
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> {1'b0, idx} < head.cnt)
    else $error("token index beyond bundle size");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !ovalid)
    else $error("output valid after reset");
`endif

endmodule

// File: verif/tb_lox_lexical_scanner.sv
// ----------------------------------------------------------------------------
// tb_lox_lexical_scanner
// Streams source bytes into the scanner and compares every token against a
// cycle-free model of the lexer kept inside this bench.
// ----------------------------------------------------------------------------
module tb_lox_lexical_scanner;
  timeunit 1ns;
  timeprecision 1ps;
  import lls_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  // Scanner modes as seen by the token model.
  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_COMMENT, S_STRING, S_INT, S_DOT, S_FRAC, S_IDENT
  } scan_mode_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  push = 1'b0;
  logic  pop = 1'b0;
  in_t   item = '0;
  logic  full, empty;
  out_t  token;

  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_cycles = 0;
  int    errors = 0;
  int    quiet_cycles = 0;
  out_t  token_queue[$];

  // Lexer state of the model.
  scan_mode_t  lx_mode;
  logic [2:0]  lx_op;
  logic [31:0] lx_pos, lx_start, lx_line;
  logic [47:0] lx_kbuf;
  logic [2:0]  lx_ilen;
  out_t        run_tokens[$];

  lox_lexical_scanner uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .token(token)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void lex_reset();
    lx_mode = S_IDLE; lx_op = OP_BANG; lx_pos = 0; lx_start = 0; lx_line = 1;
    lx_kbuf = 0; lx_ilen = 0;
  endfunction

  function automatic void add_token(logic [5:0] kind, logic [31:0] start,
                                    logic [31:0] len);
    out_t t;
    if (run_tokens.size() >= 4) return;
    t.token_kind = kind; t.start_offset = start; t.token_length = len;
    t.line_number = lx_line; t.last_of_run = 1'b0;
    run_tokens.push_back(t);
  endfunction

  function automatic void add_span(logic [5:0] kind, logic [31:0] start,
                                   logic [31:0] stop);
    add_token(kind, start, (stop >= start) ? stop - start : 32'd0);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] word_kind();
    string words[16] = '{"and", "class", "else", "false", "fun", "for", "if",
      "nil", "or", "print", "return", "super", "this", "true", "var", "while"};
    logic [47:0] packed_word;
    for (int k = 0; k < 16; k++) begin
      packed_word = 0;
      for (int i = 0; i < words[k].len(); i++)
        packed_word |= 48'(words[k][i]) << (8 * i);
      if (lx_ilen == words[k].len() && packed_word == lx_kbuf)
        return K_KW_BASE + 6'(k);
    end
    return K_IDENT;
  endfunction

  function automatic logic [5:0] single_op(logic [2:0] p);
    case (p)
      OP_BANG: return K_BANG;
      OP_EQ: return K_EQ;
      OP_LT: return K_LT;
      OP_GT: return K_GT;
      default: return K_SLASH;
    endcase
  endfunction

  function automatic logic [5:0] double_op(logic [2:0] p);
    case (p)
      OP_BANG: return K_BANG_EQ;
      OP_EQ: return K_EQ_EQ;
      OP_LT: return K_LT_EQ;
      default: return K_GT_EQ;
    endcase
  endfunction

  function automatic void bump_line();
    if (lx_line != 32'hFFFF_FFFF) lx_line++;
  endfunction

  function automatic void close_open(logic [31:0] stop);
    logic [31:0] dot_at;
    dot_at = (stop > 0) ? stop - 1 : 0;
    case (lx_mode)
      S_OP: add_token(single_op(lx_op), lx_start, 1);
      S_INT, S_FRAC: add_span(K_NUMBER, lx_start, stop);
      S_DOT: begin
        add_span(K_NUMBER, lx_start, dot_at);
        add_token(K_DOT, dot_at, 1);
      end
      S_IDENT: add_span(word_kind(), lx_start, stop);
      default: ;
    endcase
    lx_mode = S_IDLE;
  endfunction

  function automatic void start_token(logic [7:0] c, logic [31:0] pos);
    lx_start = pos;
    case (c)
      "(": add_token(K_LPAREN, pos, 1);
      ")": add_token(K_RPAREN, pos, 1);
      "{": add_token(K_LBRACE, pos, 1);
      "}": add_token(K_RBRACE, pos, 1);
      ",": add_token(K_COMMA, pos, 1);
      ".": add_token(K_DOT, pos, 1);
      "-": add_token(K_MINUS, pos, 1);
      "+": add_token(K_PLUS, pos, 1);
      ";": add_token(K_SEMI, pos, 1);
      "*": add_token(K_STAR, pos, 1);
      "!": begin lx_mode = S_OP; lx_op = OP_BANG; end
      "=": begin lx_mode = S_OP; lx_op = OP_EQ; end
      "<": begin lx_mode = S_OP; lx_op = OP_LT; end
      ">": begin lx_mode = S_OP; lx_op = OP_GT; end
      "/": begin lx_mode = S_OP; lx_op = OP_SLASH; end
      "\"": lx_mode = S_STRING;
      " ", 8'd13, 8'd9: ;
      8'd10: bump_line();
      default: begin
        if (is_digit(c)) lx_mode = S_INT;
        else if (is_alpha(c)) begin
          lx_mode = S_IDENT; lx_kbuf = 48'(c); lx_ilen = 1;
        end else add_token(K_BAD, pos, 1);
      end
    endcase
  endfunction

  // Computes the tokens that one source byte releases and queues them.
  function automatic void scan_byte(in_t b);
    logic [7:0]  c;
    logic [31:0] pos, nxt;
    bit          rescan;
    c = b.source_byte; pos = lx_pos;
    nxt = (pos == 32'hFFFF_FFFF) ? pos : pos + 1;
    rescan = 0;
    run_tokens.delete();
    case (lx_mode)
      S_OP: begin
        if (c == "=" && lx_op != OP_SLASH) begin
          add_span(double_op(lx_op), lx_start, nxt); lx_mode = S_IDLE;
        end else if (c == "/" && lx_op == OP_SLASH) lx_mode = S_COMMENT;
        else begin close_open(pos); rescan = 1; end
      end
      S_COMMENT: if (c == 8'd10) begin bump_line(); lx_mode = S_IDLE; end
      S_STRING: begin
        if (c == "\"") begin add_span(K_STRING, lx_start, nxt); lx_mode = S_IDLE; end
        else if (c == 8'd10) bump_line();
      end
      S_INT: begin
        if (c == ".") lx_mode = S_DOT;
        else if (!is_digit(c)) begin close_open(pos); rescan = 1; end
      end
      S_DOT: begin
        if (is_digit(c)) lx_mode = S_FRAC;
        else begin close_open(pos); rescan = 1; end
      end
      S_FRAC: if (!is_digit(c)) begin close_open(pos); rescan = 1; end
      S_IDENT: begin
        if (is_alpha(c) || is_digit(c)) begin
          if (lx_ilen < 6) lx_kbuf |= 48'(c) << (8 * lx_ilen);
          if (lx_ilen < 7) lx_ilen++;
        end else begin close_open(pos); rescan = 1; end
      end
      default: rescan = 1;
    endcase
    if (rescan) start_token(c, pos);
    lx_pos = nxt;
    if (b.end_of_source) begin
      if (lx_mode == S_STRING) add_span(K_UNTERM, lx_start, lx_pos);
      else close_open(lx_pos);
      add_token(K_END, lx_pos, 0);
      lex_reset();
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
    foreach (run_tokens[i]) token_queue.push_back(run_tokens[i]);
  endfunction

  // Offers one byte, idling at random beforehand, and waits for acceptance.
  task automatic send_byte(logic [7:0] c, logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= '{source_byte: c, end_of_source: eos};
    @(posedge clk);
    while (full) @(posedge clk);
    scan_byte('{source_byte: c, end_of_source: eos});
  endtask

  task automatic send_text(string s, bit eos);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eos && i == s.len() - 1);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: pops at random, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (token_queue.size() == 0) begin
          $display("%0t: unexpected token %p", $realtime, token);
          errors++;
        end else begin
          if (token !== token_queue[0]) begin
            $display("%0t: mismatch expected %p actual %p", $realtime,
                     token_queue[0], token);
            errors++;
          end
          void'(token_queue.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb_lox_lexical_scanner: FAIL");
      $finish;
    end
  end

  task automatic test_operators();
    send_text("(){},.-+;*! != = == < <= > >= / x", 1);
    send_text("!", 1);
    send_text("/", 1);
  endtask

  task automatic test_comments_strings();
    send_text("a//note\nb \"s\nt\" \"open\nend", 1);
    send_text("// tail", 1);
  endtask

  task automatic test_numbers_words();
    send_text("12.5 7. x 3.a and class else false fun for if nil or print", 0);
    send_text(" return super this true var while whiles returnx _a9 r", 1);
  endtask

  task automatic test_bad_bytes();
    send_byte(8'h00, 0); send_byte(8'hFF, 0); send_byte("@", 0);
    send_byte(8'h80, 0); send_byte(8'h7F, 1);
  endtask

  task automatic test_random(int n);
    string alphabet = "(){},.-+;*!=<>/\" \n\t\r0123456789.abcdefrinstuvwhl_Z";
    string words[6] = '{"while", "return", "super", "class", "x1", "3.14"};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_byte(8'($urandom), $urandom_range(19) == 0);
        1, 2: send_text(words[$urandom_range(5)], $urandom_range(9) == 0);
        default: send_byte(alphabet[$urandom_range(alphabet.len() - 1)],
                           $urandom_range(24) == 0);
      endcase
    end
    send_byte(" ", 1);
  endtask

  task automatic test_back_pressure();
    hold_cycles = 60;
    send_text("(((((((((( 1.x 2.y 3.z ))))))))))", 1);
  endtask

  initial begin
    lex_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_operators();
    test_comments_strings();
    test_numbers_words();
    test_bad_bytes();
    drain();
    send_idle_pct = 9; recv_idle_pct = 84;
    test_random(60);
    test_back_pressure();
    send_idle_pct = 84; recv_idle_pct = 9;
    test_random(60);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(60);
    drain();
    if (errors == 0) begin
      $display("tb_lox_lexical_scanner: PASS");
    end else begin
      $display("tb_lox_lexical_scanner: FAIL");
    end
    $finish;
  end
endmodule
